>>> rtl/i2cbc_pkg.sv
// Shared types and constants for the I2C bus-clear sequencer.
package i2cbc_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FAIL_THRESHOLD    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CLOCK_PULSES  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD_TICKS = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BUS_ENABLED       = 2'd3;

  localparam logic [7:0]  FAIL_THRESHOLD_RESET    = 8'd3;
  localparam logic [4:0]  MAX_CLOCK_PULSES_RESET  = 5'd9;
  localparam logic [15:0] HALF_PERIOD_TICKS_RESET = 16'd5;

  localparam logic [7:0] FAIL_COUNT_MAX  = 8'hFF;
  localparam logic [4:0] PULSE_COUNT_MAX = 5'h1F;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_RECOVERED = 2'd1,
    EV_STUCK     = 2'd2,
    EV_REFUSED   = 2'd3
  } event_t;

  typedef struct packed {
    logic [7:0] fail_threshold;
    logic [4:0] max_clock_pulses;
    logic       bus_enabled;
  } cfg_t;

  typedef struct packed {
    logic sda_level;
    logic outcome_valid;
    logic outcome_ok;
    logic recover_request;
  } tick_t;

endpackage

>>> rtl/i2cbc_ifs.sv
// Handshake channels for tick items and result items.
interface i2cbc_item_if;
  logic valid;
  logic ready;
  logic sda_level;
  logic outcome_valid;
  logic outcome_ok;
  logic recover_request;

  modport source(output valid, sda_level, outcome_valid, outcome_ok, recover_request,
                 input ready);
  modport sink(input valid, sda_level, outcome_valid, outcome_ok, recover_request,
               output ready);
endinterface

interface i2cbc_result_if;
  logic       valid;
  logic       ready;
  logic       scl_drive_low;
  logic       sda_drive_low;
  logic       recovery_busy;
  logic [1:0] event_code;
  logic [7:0] failure_count;

  modport source(output valid, scl_drive_low, sda_drive_low, recovery_busy, event_code,
                 failure_count, input ready);
  modport sink(input valid, scl_drive_low, sda_drive_low, recovery_busy, event_code,
               failure_count, output ready);
endinterface

>>> rtl/i2cbc_cfg.sv
// Configuration registers and the clipped half-period timer target.
module i2cbc_cfg #(
  parameter int TIMER_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [i2cbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [i2cbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output i2cbc_pkg::cfg_t                  cfg,
  output logic [TIMER_BITS-1:0]            target
);
  import i2cbc_pkg::*;

  localparam logic [32:0] TimerMax = (33'd1 << TIMER_BITS) - 33'd1;

  logic [15:0] half_period_ticks;
  logic [32:0] hp_ext;
  logic [32:0] target_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fail_threshold   <= FAIL_THRESHOLD_RESET;
      cfg.max_clock_pulses <= MAX_CLOCK_PULSES_RESET;
      cfg.bus_enabled      <= 1'b0;
      half_period_ticks    <= HALF_PERIOD_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FAIL_THRESHOLD:    cfg.fail_threshold   <= cfg_data[7:0];
        REG_MAX_CLOCK_PULSES:  cfg.max_clock_pulses <= cfg_data[4:0];
        REG_HALF_PERIOD_TICKS: half_period_ticks    <= cfg_data;
        REG_BUS_ENABLED:       cfg.bus_enabled      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Zero counts as one tick; clip to what the timer can hold.
  always_comb begin
    hp_ext = {17'd0, half_period_ticks};
    if (hp_ext == 33'd0) begin
      target_ext = 33'd1;
    end else if (hp_ext > TimerMax) begin
      target_ext = TimerMax;
    end else begin
      target_ext = hp_ext;
    end
  end

  assign target = target_ext[TIMER_BITS-1:0];

endmodule

>>> rtl/i2cbc_in_reg.sv
// Input register stage for tick items.
module i2cbc_in_reg (
  input  logic            clk,
  input  logic            rst,
  i2cbc_item_if.sink      item,
  input  logic            take,
  output logic            tick_valid,
  output i2cbc_pkg::tick_t tick
);
  import i2cbc_pkg::*;

  assign item.ready = !tick_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (item.ready) begin
      tick_valid <= item.valid;
    end
    if (item.ready && item.valid) begin
      tick.sda_level       <= item.sda_level;
      tick.outcome_valid   <= item.outcome_valid;
      tick.outcome_ok      <= item.outcome_ok;
      tick.recover_request <= item.recover_request;
    end
  end

endmodule

>>> rtl/i2cbc_seq.sv
// Recovery state machine, failure counter and result register.
module i2cbc_seq #(
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  i2cbc_pkg::cfg_t       cfg,
  input  logic [TIMER_BITS-1:0] target,
  input  logic                  tick_valid,
  input  i2cbc_pkg::tick_t      tick,
  output logic                  take,
  i2cbc_result_if.source        result
);
  import i2cbc_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_SETTLE       = 3'd1,
    PH_PULSE_LOW    = 3'd2,
    PH_PULSE_HIGH   = 3'd3,
    PH_STOP_LOW     = 3'd4,
    PH_STOP_CLOCK   = 3'd5,
    PH_STOP_RELEASE = 3'd6
  } phase_t;

  phase_t                phase, phase_next;
  logic [7:0]            fail_counter, fail_counter_next;
  logic [TIMER_BITS-1:0] wait_counter, wait_counter_next;
  logic [4:0]            pulse_counter, pulse_counter_next;
  logic                  line_freed, line_freed_next;
  event_t                event_next;

  logic                  trigger;
  logic [7:0]            fail_inc;
  logic [TIMER_BITS:0]   wait_inc;
  logic [4:0]            pulse_sample;
  phase_t                sample_phase;

  assign take = tick_valid && (!result.valid || result.ready);

  always_comb begin
    phase_next         = phase;
    fail_counter_next  = fail_counter;
    wait_counter_next  = wait_counter;
    pulse_counter_next = pulse_counter;
    line_freed_next    = line_freed;
    event_next         = EV_NONE;
    trigger            = tick.recover_request;
    fail_inc           = (fail_counter == FAIL_COUNT_MAX) ? fail_counter : fail_counter + 8'd1;
    wait_inc           = {1'b0, wait_counter} + {{TIMER_BITS{1'b0}}, 1'b1};
    // Pulse count as seen when SDA is sampled; the high half of a pulse counts it first.
    pulse_sample       = (phase == PH_PULSE_HIGH && pulse_counter != PULSE_COUNT_MAX) ?
                         pulse_counter + 5'd1 : pulse_counter;
    sample_phase       = (tick.sda_level || pulse_sample >= cfg.max_clock_pulses) ?
                         PH_STOP_LOW : PH_PULSE_LOW;

    if (phase == PH_IDLE) begin
      if (tick.outcome_valid) begin
        if (tick.outcome_ok) begin
          fail_counter_next = 8'd0;
        end else begin
          fail_counter_next = fail_inc;
          if (fail_inc >= cfg.fail_threshold) begin
            trigger = 1'b1;
          end
        end
      end
      if (trigger) begin
        if (cfg.bus_enabled) begin
          phase_next         = PH_SETTLE;
          wait_counter_next  = '0;
          pulse_counter_next = 5'd0;
          line_freed_next    = 1'b0;
        end else begin
          event_next = EV_REFUSED;
        end
      end
    end else if (wait_inc >= {1'b0, target}) begin
      wait_counter_next = '0;
      unique case (phase)
        PH_SETTLE: begin
          line_freed_next = tick.sda_level;
          phase_next      = sample_phase;
        end
        PH_PULSE_LOW: phase_next = PH_PULSE_HIGH;
        PH_PULSE_HIGH: begin
          pulse_counter_next = pulse_sample;
          line_freed_next    = tick.sda_level;
          phase_next         = sample_phase;
        end
        PH_STOP_LOW:   phase_next = PH_STOP_CLOCK;
        PH_STOP_CLOCK: phase_next = PH_STOP_RELEASE;
        default: begin
          phase_next        = PH_IDLE;
          fail_counter_next = 8'd0;
          event_next        = line_freed ? EV_RECOVERED : EV_STUCK;
        end
      endcase
    end else begin
      wait_counter_next = wait_inc[TIMER_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      fail_counter  <= 8'd0;
      wait_counter  <= '0;
      pulse_counter <= 5'd0;
      line_freed    <= 1'b0;
      result.valid  <= 1'b0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        fail_counter  <= fail_counter_next;
        wait_counter  <= wait_counter_next;
        pulse_counter <= pulse_counter_next;
        line_freed    <= line_freed_next;
        result.valid  <= 1'b1;
      end else if (result.ready) begin
        result.valid  <= 1'b0;
      end
    end
    if (take) begin
      result.scl_drive_low <= (phase_next == PH_PULSE_LOW) || (phase_next == PH_STOP_LOW);
      result.sda_drive_low <= (phase_next == PH_STOP_LOW) || (phase_next == PH_STOP_CLOCK);
      result.recovery_busy <= (phase_next != PH_IDLE);
      result.event_code    <= event_next;
      result.failure_count <= fail_counter_next;
    end
  end

endmodule

>>> rtl/i2c_bus_clear_sequencer_top.sv
// I2C bus-clear sequencer: one timer tick per item, one result per tick, showing the
// state after that tick. Ticks are taken every clock cycle when the result side keeps
// up; the accepting edge loads the input register, and a later edge, once the result side
// has room, loads the result register that also holds the updated sequencer state. The
// combinational state update between those registers sets the rate of one tick per
// cycle while the result side keeps up. A failure reaching fail_threshold, or a
// recovery request, starts a bus clear while bus_enabled is set: SDA released with SCL
// high for one half period, up to max_clock_pulses SCL pulses until SDA reads high,
// then a STOP; each phase lasts half_period_ticks ticks (zero counts as one).
module i2c_bus_clear_sequencer_top #(
  parameter int TIMER_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  i2cbc_item_if.sink                       item,
  i2cbc_result_if.source                   result,
  input  logic                             cfg_write,
  input  logic [i2cbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [i2cbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import i2cbc_pkg::*;

  cfg_t                  cfg;
  logic [TIMER_BITS-1:0] target;
  logic                  tick_valid;
  tick_t                 tick;
  logic                  take;

  i2cbc_cfg #(
    .TIMER_BITS(TIMER_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg),
    .target   (target)
  );

  i2cbc_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .take      (take),
    .tick_valid(tick_valid),
    .tick      (tick)
  );

  i2cbc_seq #(
    .TIMER_BITS(TIMER_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .target    (target),
    .tick_valid(tick_valid),
    .tick      (tick),
    .take      (take),
    .result    (result)
  );

endmodule

>>> tb/i2cbc_tick_checker.sv
// Checker for the I2C bus-clear sequencer: predicts each tick's result and compares it.
`timescale 1ns / 1ps

module i2cbc_tick_checker #(
  parameter int TIMER_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  i2cbc_item_if                             item,
  i2cbc_result_if                           result,
  input  logic                              cfg_write,
  input  logic [i2cbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [i2cbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                errors,
  output int                                outstanding
);
  import i2cbc_pkg::*;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SETTLE,
    SEQ_PULSE_LOW,
    SEQ_PULSE_HIGH,
    SEQ_STOP_LOW,
    SEQ_STOP_CLOCK,
    SEQ_STOP_RELEASE
  } seq_phase_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy;
    event_t     ev;
    logic [7:0] count;
  } bus_view_t;

  cfg_t        regs;
  logic [15:0] half_ticks;

  seq_phase_t  seq_phase;
  logic [7:0]  fail_count;
  int unsigned wait_ticks;
  logic [4:0]  pulses_done;
  logic        sda_freed;

  bus_view_t   expected_views[$];

  initial begin
    errors = 0;
    outstanding = 0;
  end

  // Sample SDA at the end of a high half period and pick pulse or STOP.
  function automatic void sample_sda(logic sda);
    sda_freed = sda;
    if (sda || pulses_done >= regs.max_clock_pulses) seq_phase = SEQ_STOP_LOW;
    else seq_phase = SEQ_PULSE_LOW;
  endfunction

  function automatic bus_view_t advance_sequencer(tick_t t);
    bus_view_t view;
    logic      trigger;
    longint    target;
    view.ev = EV_NONE;
    target = (half_ticks == 16'd0) ? 1 : longint'(half_ticks);
    if (target > (longint'(1) << TIMER_BITS) - 1) target = (longint'(1) << TIMER_BITS) - 1;
    if (seq_phase == SEQ_IDLE) begin
      trigger = t.recover_request;
      if (t.outcome_valid) begin
        if (t.outcome_ok) begin
          fail_count = '0;
        end else begin
          if (fail_count != FAIL_COUNT_MAX) fail_count++;
          if (fail_count >= regs.fail_threshold) trigger = 1'b1;
        end
      end
      if (trigger) begin
        if (regs.bus_enabled) begin
          seq_phase = SEQ_SETTLE;
          wait_ticks = 0;
          pulses_done = '0;
          sda_freed = 1'b0;
        end else begin
          view.ev = EV_REFUSED;
        end
      end
    end else begin
      wait_ticks++;
      if (longint'(wait_ticks) >= target) begin
        wait_ticks = 0;
        case (seq_phase)
          SEQ_SETTLE: sample_sda(t.sda_level);
          SEQ_PULSE_LOW: seq_phase = SEQ_PULSE_HIGH;
          SEQ_PULSE_HIGH: begin
            if (pulses_done != PULSE_COUNT_MAX) pulses_done++;
            sample_sda(t.sda_level);
          end
          SEQ_STOP_LOW: seq_phase = SEQ_STOP_CLOCK;
          SEQ_STOP_CLOCK: seq_phase = SEQ_STOP_RELEASE;
          default: begin
            seq_phase = SEQ_IDLE;
            fail_count = '0;
            view.ev = sda_freed ? EV_RECOVERED : EV_STUCK;
          end
        endcase
      end
    end
    view.scl_low = (seq_phase == SEQ_PULSE_LOW) || (seq_phase == SEQ_STOP_LOW);
    view.sda_low = (seq_phase == SEQ_STOP_LOW) || (seq_phase == SEQ_STOP_CLOCK);
    view.busy    = (seq_phase != SEQ_IDLE);
    view.count   = fail_count;
    return view;
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    bus_view_t want;
    tick_t     t;
    if (rst) begin
      regs.fail_threshold   = FAIL_THRESHOLD_RESET;
      regs.max_clock_pulses = MAX_CLOCK_PULSES_RESET;
      regs.bus_enabled      = 1'b0;
      half_ticks            = HALF_PERIOD_TICKS_RESET;
      seq_phase             = SEQ_IDLE;
      fail_count            = '0;
      wait_ticks            = 0;
      pulses_done           = '0;
      sda_freed             = 1'b0;
      expected_views.delete();
    end else begin
      // A result can never belong to the tick taken on the same edge, so check first.
      if (result.valid && result.ready) begin
        if (expected_views.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, got scl %b sda %b busy %b ev %0d cnt %0d",
                   $time, result.scl_drive_low, result.sda_drive_low, result.recovery_busy,
                   result.event_code, result.failure_count);
        end else begin
          want = expected_views.pop_front();
          compare_field("scl_drive_low", 8'(want.scl_low), 8'(result.scl_drive_low));
          compare_field("sda_drive_low", 8'(want.sda_low), 8'(result.sda_drive_low));
          compare_field("recovery_busy", 8'(want.busy), 8'(result.recovery_busy));
          compare_field("event_code", 8'(want.ev), 8'(result.event_code));
          compare_field("failure_count", want.count, result.failure_count);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_FAIL_THRESHOLD:   regs.fail_threshold = cfg_data[7:0];
          REG_MAX_CLOCK_PULSES: regs.max_clock_pulses = cfg_data[4:0];
          REG_HALF_PERIOD_TICKS: half_ticks = cfg_data[15:0];
          REG_BUS_ENABLED:      regs.bus_enabled = cfg_data[0];
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        t.sda_level       = item.sda_level;
        t.outcome_valid   = item.outcome_valid;
        t.outcome_ok      = item.outcome_ok;
        t.recover_request = item.recover_request;
        expected_views.push_back(advance_sequencer(t));
      end
    end
    outstanding = expected_views.size();
  end

endmodule

>>> tb/tb.sv
// Testbench top for the I2C bus-clear sequencer: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
  import i2cbc_pkg::*;

  localparam int RESET_CYCLES    = 7;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_LIMIT      = 3000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int errors;
  int outstanding;
  int idle_cycles = 0;
  int hold_req = 0;
  int hold_done = 0;
  int burst_left = 0;

  i2cbc_item_if   item_ch ();
  i2cbc_result_if result_ch ();

  always #6 clk = ~clk;

  i2c_bus_clear_sequencer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  i2cbc_tick_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("tb: FAIL");
    $finish;
  end

  // Result side: stretches of always-ready, random, mostly-ready and mostly-stalled, plus long hold-offs.
  initial begin : result_stall
    int stretch;
    int mode;
    result_ch.ready <= 1'b0;
    forever begin
      stretch = $urandom_range(4, 60);
      mode = $urandom_range(0, 3);
      repeat (stretch) begin
        @(posedge clk);
        if (hold_done != hold_req) begin
          result_ch.ready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
          hold_done++;
        end
        case (mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= 1'($urandom_range(0, 1));
          2: result_ch.ready <= ($urandom_range(0, 3) != 0);
          default: result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic tick_t make_tick(logic sda, logic ov, logic ok, logic req);
    tick_t t;
    t.sda_level       = sda;
    t.outcome_valid   = ov;
    t.outcome_ok      = ok;
    t.recover_request = req;
    return t;
  endfunction

  function automatic tick_t random_tick(int sda_pct, int outcome_pct, int fail_pct, int req_pct);
    tick_t t;
    t.sda_level       = ($urandom_range(0, 99) < sda_pct);
    t.outcome_valid   = ($urandom_range(0, 99) < outcome_pct);
    // outcome_ok is don't-care without outcome_valid, so toggle it freely there
    t.outcome_ok      = t.outcome_valid ? ($urandom_range(0, 99) >= fail_pct)
                                        : 1'($urandom_range(0, 1));
    t.recover_request = ($urandom_range(0, 99) < req_pct);
    return t;
  endfunction

  // Offer one tick; bursts of random length with random gaps between them.
  task automatic offer(tick_t t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    item_ch.valid           <= 1'b1;
    item_ch.sda_level       <= t.sda_level;
    item_ch.outcome_valid   <= t.outcome_valid;
    item_ch.outcome_ok      <= t.outcome_ok;
    item_ch.recover_request <= t.recover_request;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic run_ticks(int count, int sda_pct, int outcome_pct, int fail_pct, int req_pct);
    repeat (count) offer(random_tick(sda_pct, outcome_pct, fail_pct, req_pct));
  endtask

  // Drop valid and hold until every result is back, then let the pipeline settle.
  task automatic drain();
    item_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reconfigure(logic [7:0] thr, logic [4:0] pulses, logic [15:0] half,
                             logic en);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= REG_FAIL_THRESHOLD;
    cfg_data  <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_index <= REG_MAX_CLOCK_PULSES;
    cfg_data  <= CFG_DATA_W'(pulses);
    @(posedge clk);
    cfg_index <= REG_HALF_PERIOD_TICKS;
    cfg_data  <= half;
    @(posedge clk);
    cfg_index <= REG_BUS_ENABLED;
    cfg_data  <= CFG_DATA_W'(en);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    item_ch.valid           <= 1'b0;
    item_ch.sda_level       <= 1'b0;
    item_ch.outcome_valid   <= 1'b0;
    item_ch.outcome_ok      <= 1'b0;
    item_ch.recover_request <= 1'b0;
    cfg_write               <= 1'b0;
    cfg_index               <= REG_FAIL_THRESHOLD;
    cfg_data                <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Bus disabled after reset: threshold hits and requests are refused, count kept.
    offer(make_tick(1'b0, 1'b0, 1'b0, 1'b0));
    offer(make_tick(1'b1, 1'b0, 1'b1, 1'b0));
    offer(make_tick(1'b0, 1'b1, 1'b0, 1'b0));
    offer(make_tick(1'b0, 1'b1, 1'b0, 1'b0));
    offer(make_tick(1'b0, 1'b1, 1'b0, 1'b0));
    offer(make_tick(1'b1, 1'b1, 1'b0, 1'b0));
    offer(make_tick(1'b0, 1'b1, 1'b1, 1'b0));
    offer(make_tick(1'b0, 1'b0, 1'b0, 1'b1));
    offer(make_tick(1'b1, 1'b1, 1'b0, 1'b1));

    // Zero threshold, zero pulse limit, zero half period.
    reconfigure(8'd0, 5'd0, 16'd0, 1'b1);
    offer(make_tick(1'b0, 1'b1, 1'b1, 1'b0));
    offer(make_tick(1'b0, 1'b1, 1'b0, 1'b0));
    offer(make_tick(1'b0, 1'b1, 1'b0, 1'b1));
    offer(make_tick(1'b0, 1'b0, 1'b0, 1'b1));
    offer(make_tick(1'b1, 1'b1, 1'b1, 1'b0));
    offer(make_tick(1'b0, 1'b0, 1'b0, 1'b0));
    offer(make_tick(1'b1, 1'b0, 1'b0, 1'b1));
    offer(make_tick(1'b1, 1'b0, 1'b0, 1'b0));
    offer(make_tick(1'b1, 1'b1, 1'b0, 1'b0));
    offer(make_tick(1'b1, 1'b0, 1'b0, 1'b0));
    offer(make_tick(1'b1, 1'b0, 1'b0, 1'b0));
    offer(make_tick(1'b0, 1'b1, 1'b0, 1'b0));

    reconfigure(8'd1, 5'd1, 16'd1, 1'b1);
    run_ticks(150, 50, 60, 50, 5);

    // Saturate the failure count while refused.
    reconfigure(8'd255, 5'd16, 16'd1, 1'b0);
    run_ticks(300, 50, 100, 100, 0);

    // Saturated count retriggers at once; long pulse trains while the receiver holds off.
    reconfigure(8'd255, 5'd31, 16'd2, 1'b1);
    hold_req++;
    run_ticks(200, 10, 60, 70, 3);

    // Longest half period, then shorten it and clear the enable mid-recovery.
    reconfigure(8'd2, 5'd16, 16'hFFFF, 1'b1);
    offer(make_tick(1'b0, 1'b0, 1'b0, 1'b1));
    run_ticks(30, 30, 60, 50, 10);
    reconfigure(8'd2, 5'd16, 16'd3, 1'b0);
    run_ticks(120, 40, 60, 50, 5);

    reconfigure(8'd4, 5'd5, 16'd4, 1'b1);
    run_ticks(100, 30, 60, 60, 3);
    drain();
    run_ticks(100, 30, 60, 60, 3);

    reconfigure(8'd3, 5'd9, 16'd1, 1'b1);
    hold_req++;
    run_ticks(250, 50, 60, 50, 4);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
